// ----- sv/cpi_pkg.sv -----
// Shared widths, codes, types and the clamp helper function of the current-loop PI regulator.
`default_nettype none

package cpi_pkg;

  // Field widths.
  localparam int CUR_W     = 16;
  localparam int ERR_W     = 17;
  localparam int APPLIED_W = 21;
  localparam int VOLT_W    = 17;
  localparam int GAIN_W    = 23;
  localparam int LIMIT_W   = 16;

  // Internal arithmetic widths. A product of a 17-bit error and a 24-bit signed gain
  // fits 41 bits, and one more bit covers every sum of a product and a term.
  localparam int PROD_W = ERR_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 1;

  // Default number of fraction bits in the gains.
  localparam int GAIN_FRAC_BITS_DEF = 15;

  // Register file layout.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INT_GAIN  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OUT_LIMIT = 2'd2;

  localparam logic [LIMIT_W-1:0] OUT_LIMIT_RESET = 16'd12000;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_PROCESS = 2'd0,
    OP_SEED    = 2'd1,
    OP_TRACK   = 2'd2,
    OP_CLEAR   = 2'd3
  } cpi_op_e;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  int_gain;
    logic [LIMIT_W-1:0] out_limit;
  } cpi_cfg_t;

  // Scaled terms handed from the multiplier stage to the state update.
  typedef struct packed {
    cpi_op_e                       op;
    logic                          err_pos;
    logic                          err_neg;
    logic signed [PROD_W-1:0]      p_term;
    logic signed [PROD_W-1:0]      i_step;
    logic signed [APPLIED_W-1:0]   applied;
  } cpi_prod_t;

  // Symmetric clamp of a wide signed value to +-lim.
  function automatic logic signed [VOLT_W-1:0] clamp_sym(
    input logic signed [SUM_W-1:0] v,
    input logic [LIMIT_W-1:0]      lim
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [VOLT_W-1:0] res;
    hi = $signed(SUM_W'(lim));
    if (v > hi) begin
      res = VOLT_W'(hi);
    end else if (v < -hi) begin
      res = VOLT_W'(-hi);
    end else begin
      res = VOLT_W'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- sv/cpi_in_if.sv -----
// Input channel of the PI regulator: valid/ready handshake with one command item.
`default_nettype none

interface cpi_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             operation;
  logic signed [cpi_pkg::CUR_W-1:0]       reference_current;
  logic signed [cpi_pkg::CUR_W-1:0]       measured_current;
  logic signed [cpi_pkg::APPLIED_W-1:0]   applied_voltage;

  modport source (
    output valid, operation, reference_current, measured_current, applied_voltage,
    input  ready
  );
  modport sink (
    input  valid, operation, reference_current, measured_current, applied_voltage,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/cpi_out_if.sv -----
// Output channel of the PI regulator: valid/ready handshake with one result item.
`default_nettype none

interface cpi_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cpi_pkg::VOLT_W-1:0]   drive_voltage;
  logic signed [cpi_pkg::VOLT_W-1:0]   integral_value;

  modport source (
    output valid, drive_voltage, integral_value,
    input  ready
  );
  modport sink (
    input  valid, drive_voltage, integral_value,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/cpi_regs.sv -----
// APB register file holding the gains and the output limit.
`default_nettype none

module cpi_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [cpi_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [cpi_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [cpi_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready,
  output cpi_pkg::cpi_cfg_t                      cfg_o
);
  import cpi_pkg::*;

  logic [GAIN_W-1:0]    prop_gain_q;
  logic [GAIN_W-1:0]    int_gain_q;
  logic [LIMIT_W-1:0]   out_limit_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  // Word index of the addressed register.
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q <= '0;
      int_gain_q  <= '0;
      out_limit_q <= OUT_LIMIT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PROP_GAIN: prop_gain_q <= pwdata[GAIN_W-1:0];
        REG_INT_GAIN:  int_gain_q  <= pwdata[GAIN_W-1:0];
        REG_OUT_LIMIT: out_limit_q <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (reg_idx)
      REG_PROP_GAIN: prdata = APB_DATA_W'(prop_gain_q);
      REG_INT_GAIN:  prdata = APB_DATA_W'(int_gain_q);
      REG_OUT_LIMIT: prdata = APB_DATA_W'(out_limit_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.prop_gain = prop_gain_q;
  assign cfg_o.int_gain  = int_gain_q;
  assign cfg_o.out_limit = out_limit_q;

endmodule

`default_nettype wire

// ----- sv/cpi_gain.sv -----
// Input register and gain multiplier stage: forms the error and both scaled terms.
`default_nettype none

module cpi_gain #(
  parameter int GAIN_FRAC_BITS = cpi_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cpi_pkg::cpi_cfg_t cfg_i,
  cpi_in_if.sink                 in_i,
  output logic                   prod_valid_o,
  input  wire logic              prod_ready_i,
  output cpi_pkg::cpi_prod_t     prod_o
);
  import cpi_pkg::*;

  // Input register.
  logic                         in_vld_q;
  cpi_op_e                      op_q;
  logic signed [CUR_W-1:0]      ref_q;
  logic signed [CUR_W-1:0]      meas_q;
  logic signed [APPLIED_W-1:0]  applied_q;

  // Product register.
  logic                         prod_vld_q;
  cpi_prod_t                    prod_q;
  cpi_prod_t                    prod_d;

  logic                         prod_free;
  logic                         in_free;
  logic                         in_take;
  logic signed [ERR_W-1:0]      err;
  logic signed [GAIN_W:0]       kp_s;
  logic signed [GAIN_W:0]       ki_s;
  logic signed [PROD_W-1:0]     p_full;
  logic signed [PROD_W-1:0]     i_full;

  // Pipeline flow: each stage moves when the one after it is empty or draining.
  assign prod_free = !prod_vld_q || prod_ready_i;
  assign in_free   = !in_vld_q || prod_free;
  assign in_i.ready = in_free;
  assign in_take   = in_i.valid && in_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      if (in_free) begin
        in_vld_q <= in_i.valid;
      end
      if (prod_free) begin
        prod_vld_q <= in_vld_q;
      end
    end
  end

  // Capture a transfer on the input channel.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q      <= cpi_op_e'(in_i.operation);
      ref_q     <= in_i.reference_current;
      meas_q    <= in_i.measured_current;
      applied_q <= in_i.applied_voltage;
    end
  end

  // Error and gain products, scaled with a flooring shift.
  assign err    = ERR_W'(ref_q) - ERR_W'(meas_q);
  assign kp_s   = $signed({1'b0, cfg_i.prop_gain});
  assign ki_s   = $signed({1'b0, cfg_i.int_gain});
  assign p_full = err * kp_s;
  assign i_full = err * ki_s;

  always_comb begin
    prod_d.op      = op_q;
    prod_d.err_pos = !err[ERR_W-1] && (err != '0);
    prod_d.err_neg = err[ERR_W-1];
    prod_d.p_term  = p_full >>> GAIN_FRAC_BITS;
    prod_d.i_step  = i_full >>> GAIN_FRAC_BITS;
    prod_d.applied = applied_q;
  end

  always_ff @(posedge clk_i) begin
    if (prod_free && in_vld_q) begin
      prod_q <= prod_d;
    end
  end

  assign prod_valid_o = prod_vld_q;
  assign prod_o       = prod_q;

endmodule

`default_nettype wire

// ----- sv/cpi_state.sv -----
// State update stage: anti-windup integration, clamps and the stored terms as result.
`default_nettype none

module cpi_state (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cpi_pkg::cpi_cfg_t  cfg_i,
  input  wire logic               prod_valid_i,
  output logic                    prod_ready_o,
  input  wire cpi_pkg::cpi_prod_t prod_i,
  cpi_out_if.source               out_o
);
  import cpi_pkg::*;

  logic                         out_vld_q;
  logic signed [VOLT_W-1:0]     integ_q;
  logic signed [VOLT_W-1:0]     integ_d;
  logic signed [VOLT_W-1:0]     drive_q;
  logic signed [VOLT_W-1:0]     drive_d;

  logic                         take;
  logic signed [SUM_W-1:0]      lim_s;
  logic signed [VOLT_W-1:0]     i_cand;
  logic signed [SUM_W-1:0]      sum;
  logic                         in_range;
  logic                         unwind;
  logic signed [VOLT_W-1:0]     proc_int;
  logic signed [VOLT_W-1:0]     proc_out;
  logic signed [VOLT_W-1:0]     applied_clamped;
  logic signed [VOLT_W-1:0]     track_int;

  // The stored terms double as the result register, so an item may only update
  // them once the previous result has been taken.
  assign prod_ready_o = !out_vld_q || out_o.ready;
  assign take         = prod_valid_i && prod_ready_o;

  assign lim_s = $signed(SUM_W'(cfg_i.out_limit));

  // Process: conditional integration of the clamped candidate.
  assign i_cand   = clamp_sym(SUM_W'(integ_q) + SUM_W'(prod_i.i_step), cfg_i.out_limit);
  assign sum      = SUM_W'(prod_i.p_term) + SUM_W'(i_cand);
  assign in_range = (sum <= lim_s) && (sum >= -lim_s);
  assign unwind   = ((sum > lim_s) && prod_i.err_neg) || ((sum < -lim_s) && prod_i.err_pos);
  assign proc_int = (in_range || unwind) ? i_cand : integ_q;
  assign proc_out = clamp_sym(SUM_W'(prod_i.p_term) + SUM_W'(proc_int), cfg_i.out_limit);

  // Seed and track share the clamped applied voltage.
  assign applied_clamped = clamp_sym(SUM_W'(prod_i.applied), cfg_i.out_limit);
  assign track_int = clamp_sym(SUM_W'(integ_q) + SUM_W'(applied_clamped) - SUM_W'(drive_q),
                               cfg_i.out_limit);

  // Next stored terms. A zero limit freezes everything but a clear.
  always_comb begin
    integ_d = integ_q;
    drive_d = drive_q;
    if (prod_i.op == OP_CLEAR) begin
      integ_d = '0;
      drive_d = '0;
    end else if (cfg_i.out_limit != '0) begin
      case (prod_i.op)
        OP_PROCESS: begin
          integ_d = proc_int;
          drive_d = proc_out;
        end
        OP_SEED: begin
          integ_d = applied_clamped;
          drive_d = applied_clamped;
        end
        OP_TRACK: begin
          integ_d = track_int;
          drive_d = applied_clamped;
        end
        default: begin
          integ_d = integ_q;
          drive_d = drive_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      integ_q   <= '0;
      drive_q   <= '0;
    end else begin
      if (prod_ready_o) begin
        out_vld_q <= prod_valid_i;
      end
      if (take) begin
        integ_q <= integ_d;
        drive_q <= drive_d;
      end
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.drive_voltage  = drive_q;
  assign out_o.integral_value = integ_q;

endmodule

`default_nettype wire

// ----- sv/current_pi_controller_antiwindup.sv -----
// Top level of the current-loop PI regulator with conditional-integration anti-windup.
//
// The regulator accepts one command per clock cycle unless the output side stalls, and
// returns exactly one result per command. A command passes, in order, the input register,
// the gain multipliers (two parallel 17 x 24 bit products, registered), and the state
// update, where the integral and output terms are clamped and stored. The stored terms
// themselves form the result register, so the integral feedback closes through that
// register and back-to-back commands see the state left by the command before.
// Configuration must be written through the APB port only while the block is idle; the
// block itself does not enforce this. pready is always high.
`default_nettype none

module current_pi_controller_antiwindup #(
  parameter int GAIN_FRAC_BITS = cpi_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [cpi_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [cpi_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [cpi_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready,
  cpi_in_if.sink                                 in_i,
  cpi_out_if.source                              out_o
);
  import cpi_pkg::*;

  cpi_cfg_t  cfg;
  cpi_prod_t prod;
  logic      prod_valid;
  logic      prod_ready;

  // Configuration registers.
  cpi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register and gain products.
  cpi_gain #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_gain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_i         (in_i),
    .prod_valid_o (prod_valid),
    .prod_ready_i (prod_ready),
    .prod_o       (prod)
  );

  // Integral and output state with the result register.
  cpi_state u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_i       (prod),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// ----- tb/cpi_checker.sv -----
// Checker for the PI regulator: predicts every result and compares it with the output channel.
`timescale 1ns / 100ps

module cpi_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [cpi_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [cpi_pkg::APB_DATA_W-1:0]   pwdata,
  cpi_in_if                                cmd_i,
  cpi_out_if                               res_i,
  output int                               errors_o,
  output int                               pending_o
);
  import cpi_pkg::*;

  // One predicted result: the stored output and integral after a command.
  typedef struct packed {
    logic signed [VOLT_W-1:0] drive;
    logic signed [VOLT_W-1:0] integral;
  } volt_pair_t;

  // Register copies as the datapath sees them.
  logic [GAIN_W-1:0]  prop_cfg;
  logic [GAIN_W-1:0]  int_cfg;
  logic [LIMIT_W-1:0] limit_cfg;

  // Regulator state in millivolts.
  logic signed [VOLT_W-1:0] integ_mv;
  logic signed [VOLT_W-1:0] out_mv;

  volt_pair_t expected_terms_q[$];
  int         errors;

  function automatic longint limit_mv(longint v, longint lim);
    if (v > lim) begin
      return lim;
    end else if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  // Applies one command to the predicted state and returns the terms it leaves behind.
  function automatic volt_pair_t regulate(cpi_op_e op,
                                          logic signed [CUR_W-1:0] target_ma,
                                          logic signed [CUR_W-1:0] sensed_ma,
                                          logic signed [APPLIED_W-1:0] applied_mv);
    longint     lim;
    longint     err;
    longint     p_mv;
    longint     step_mv;
    longint     cand_mv;
    longint     sum_mv;
    longint     a_mv;
    bit         inside_lim;
    bit         unwinding;
    volt_pair_t res;
    lim = longint'(limit_cfg);
    if (op == OP_CLEAR) begin
      integ_mv = '0;
      out_mv   = '0;
    end else if (lim > 0) begin
      case (op)
        OP_PROCESS: begin
          // Gains are unsigned Q8.15; the arithmetic shift rounds toward minus infinity.
          err     = longint'(target_ma) - longint'(sensed_ma);
          p_mv    = (err * longint'(prop_cfg)) >>> GAIN_FRAC_BITS_DEF;
          step_mv = (err * longint'(int_cfg)) >>> GAIN_FRAC_BITS_DEF;
          cand_mv = limit_mv(longint'(integ_mv) + step_mv, lim);
          sum_mv  = p_mv + cand_mv;
          inside_lim = (sum_mv <= lim) && (sum_mv >= -lim);
          unwinding  = ((sum_mv > lim) && (err < 0)) || ((sum_mv < -lim) && (err > 0));
          // Conditional integration: the integral moves only when it cannot wind up.
          if (inside_lim || unwinding) begin
            integ_mv = VOLT_W'(cand_mv);
          end
          out_mv = VOLT_W'(limit_mv(p_mv + longint'(integ_mv), lim));
        end
        OP_SEED: begin
          integ_mv = VOLT_W'(limit_mv(longint'(applied_mv), lim));
          out_mv   = integ_mv;
        end
        default: begin
          // Bumpless transfer: the integral absorbs the step to the applied output.
          a_mv     = limit_mv(longint'(applied_mv), lim);
          integ_mv = VOLT_W'(limit_mv(longint'(integ_mv) + a_mv - longint'(out_mv), lim));
          out_mv   = VOLT_W'(a_mv);
        end
      endcase
    end
    res.drive    = out_mv;
    res.integral = integ_mv;
    return res;
  endfunction

  // Results are checked before the command of the same edge is predicted, since a result
  // can never belong to a command accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    volt_pair_t want;
    if (!rst_ni) begin
      prop_cfg  = '0;
      int_cfg   = '0;
      limit_cfg = OUT_LIMIT_RESET;
      integ_mv  = '0;
      out_mv    = '0;
      errors    = 0;
      expected_terms_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_terms_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got drive %0d integral %0d",
                   $time, res_i.drive_voltage, res_i.integral_value);
        end else begin
          want = expected_terms_q.pop_front();
          if (res_i.drive_voltage !== want.drive) begin
            errors++;
            $display("%0t: drive_voltage expected %0d, got %0d",
                     $time, want.drive, res_i.drive_voltage);
          end
          if (res_i.integral_value !== want.integral) begin
            errors++;
            $display("%0t: integral_value expected %0d, got %0d",
                     $time, want.integral, res_i.integral_value);
          end
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        expected_terms_q.push_back(regulate(cpi_op_e'(cmd_i.operation),
                                            cmd_i.reference_current,
                                            cmd_i.measured_current,
                                            cmd_i.applied_voltage));
      end
      // Register writes take effect for commands after this edge.
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:2])
          REG_PROP_GAIN: prop_cfg  = pwdata[GAIN_W-1:0];
          REG_INT_GAIN:  int_cfg   = pwdata[GAIN_W-1:0];
          REG_OUT_LIMIT: limit_cfg = pwdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      errors_o  <= errors;
      pending_o <= expected_terms_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the PI regulator testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module tb_top;
  import cpi_pkg::*;

  localparam int GAIN_MAX    = (1 << GAIN_W) - 1;
  localparam int LIMIT_MAX   = (1 << LIMIT_W) - 1;
  localparam int APPLIED_MAX = (1 << (APPLIED_W - 1)) - 1;
  localparam int APPLIED_MIN = -(1 << (APPLIED_W - 1));
  localparam int CUR_MAX     = (1 << (CUR_W - 1)) - 1;
  localparam int CUR_MIN     = -(1 << (CUR_W - 1));
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_CMDS  = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  int check_errors;
  int check_pending;
  int cycle_count = 0;
  bit hold_out = 1'b0;
  bit sender_gapless = 1'b0;

  cpi_in_if  cmd_if ();
  cpi_out_if res_if ();

  current_pi_controller_antiwindup uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (cmd_if),
    .out_o   (res_if)
  );

  cpi_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .cmd_i     (cmd_if),
    .res_i     (res_if),
    .errors_o  (check_errors),
    .pending_o (check_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // One register write: setup cycle, access cycle, then the bus goes idle.
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_gains(input int prop, input int igain, input int lim);
    apb_write(REG_PROP_GAIN, prop);
    apb_write(REG_INT_GAIN, igain);
    apb_write(REG_OUT_LIMIT, lim);
  endtask

  // Offers one command after a random gap, unless the sender is gapless, and returns at the edge of its transfer.
  task automatic send_cmd(input cpi_op_e op, input int target_ma, input int sensed_ma,
                          input int applied_mv);
    int r;
    int gap;
    gap = 0;
    if (!sender_gapless) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        gap = 0;
      end else if (r < 92) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(10, 40);
      end
    end
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid             <= 1'b1;
    cmd_if.operation         <= op;
    cmd_if.reference_current <= CUR_W'(target_ma);
    cmd_if.measured_current  <= CUR_W'(sensed_ma);
    cmd_if.applied_voltage   <= APPLIED_W'(applied_mv);
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (check_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 0;
    end else if (r == 1) begin
      return GAIN_MAX;
    end else if (r < 7) begin
      return $urandom_range(0, 65536);
    end
    return $urandom_range(0, GAIN_MAX);
  endfunction

  function automatic int pick_limit();
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) begin
      return 0;
    end else if (r == 1) begin
      return 1;
    end else if (r == 2) begin
      return LIMIT_MAX;
    end
    return $urandom_range(1, 30000);
  endfunction

  // Mostly regulation steps with a near-converged error, so the integral stays in range
  // long enough to exercise conditional integration; the rest is seeds, tracks and clears.
  task automatic send_random();
    cpi_op_e op;
    int r;
    int target_ma;
    int sensed_ma;
    int span;
    int applied_mv;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      op = OP_PROCESS;
    end else if (r < 80) begin
      op = OP_SEED;
    end else if (r < 92) begin
      op = OP_TRACK;
    end else begin
      op = OP_CLEAR;
    end
    target_ma = int'($urandom_range(0, 65535)) + CUR_MIN;
    if ($urandom_range(0, 3) == 0) begin
      sensed_ma = int'($urandom_range(0, 65535)) + CUR_MIN;
    end else begin
      span = ($urandom_range(0, 1) == 0) ? 16 : 1024;
      sensed_ma = target_ma + int'($urandom_range(0, 2 * span)) - span;
      if (sensed_ma > CUR_MAX) begin
        sensed_ma = CUR_MAX;
      end else if (sensed_ma < CUR_MIN) begin
        sensed_ma = CUR_MIN;
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      applied_mv = int'($urandom_range(0, 2 * APPLIED_MAX + 1)) + APPLIED_MIN;
    end else begin
      applied_mv = int'($urandom_range(0, 140000)) - 70000;
    end
    send_cmd(op, target_ma, sensed_ma, applied_mv);
  endtask

  // Output side: random stalls, mostly short, and a long hold-off on request.
  initial begin
    int r;
    int stall;
    int run;
    res_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          stall = 0;
        end else if (r < 90) begin
          stall = $urandom_range(1, 3);
        end else begin
          stall = $urandom_range(15, 60);
        end
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 8);
        if (stall > 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        res_if.ready <= 1'b1;
        repeat (run) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n   <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    cmd_if.valid             <= 1'b0;
    cmd_if.operation         <= OP_PROCESS;
    cmd_if.reference_current <= '0;
    cmd_if.measured_current  <= '0;
    cmd_if.applied_voltage   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: zero gains, so a regulation step only replays the integral.
    send_cmd(OP_PROCESS, CUR_MAX, CUR_MIN, 0);
    send_cmd(OP_SEED, 0, 0, APPLIED_MAX);
    send_cmd(OP_TRACK, 0, 0, APPLIED_MIN);
    send_cmd(OP_CLEAR, 0, 0, 0);
    wait_idle();

    // Largest gains and limit: full-scale errors saturate, tiny negative errors round down.
    write_gains(GAIN_MAX, GAIN_MAX, LIMIT_MAX);
    send_cmd(OP_PROCESS, CUR_MAX, CUR_MIN, 0);
    send_cmd(OP_PROCESS, CUR_MIN, CUR_MAX, 0);
    send_cmd(OP_PROCESS, 0, 1, 0);
    send_cmd(OP_PROCESS, 1, 0, 0);
    send_cmd(OP_SEED, 0, 0, APPLIED_MAX);
    send_cmd(OP_PROCESS, 0, 1, 0);
    send_cmd(OP_SEED, 0, 0, APPLIED_MIN);
    send_cmd(OP_TRACK, 0, 0, 0);
    send_cmd(OP_TRACK, 0, 0, APPLIED_MAX);
    wait_idle();

    // Smallest nonzero limit.
    apb_write(REG_OUT_LIMIT, 1);
    send_cmd(OP_PROCESS, CUR_MAX, CUR_MIN, 0);
    send_cmd(OP_PROCESS, 0, 0, 0);
    send_cmd(OP_SEED, 0, 0, -5);
    wait_idle();

    // Zero limit: everything but a clear leaves the stored terms alone.
    apb_write(REG_OUT_LIMIT, 0);
    send_cmd(OP_PROCESS, 100, 0, 0);
    send_cmd(OP_SEED, 0, 0, 500);
    send_cmd(OP_TRACK, 0, 0, -500);
    send_cmd(OP_CLEAR, 0, 0, 0);
    wait_idle();

    // Limit lowered below the stored terms: they stay until an operation rewrites them.
    write_gains(0, 0, LIMIT_MAX);
    send_cmd(OP_SEED, 0, 0, 60000);
    wait_idle();
    apb_write(REG_OUT_LIMIT, 0);
    send_cmd(OP_PROCESS, 3, -3, 0);
    wait_idle();
    apb_write(REG_OUT_LIMIT, 100);
    send_cmd(OP_TRACK, 0, 0, 50);
    send_cmd(OP_PROCESS, 3, -3, 0);
    wait_idle();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_gains(pick_gain(), pick_gain(), pick_limit());
      sender_gapless = (phase % 3 == 0);
      for (int n = 0; n < PHASE_CMDS; n++) begin
        if ((phase == 2 || phase == 5) && n == 40) begin
          hold_out = 1'b1;
        end
        send_random();
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (check_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
